// File: hdl/cdr_pkg.sv
// ----------------------------------------------------------------------------
// cdr_pkg
// shared types and constants for the compact difficulty retarget block
// ----------------------------------------------------------------------------
package cdr_pkg;

	localparam int MANT_W  = 23;   // mantissa bits that are scaled
	localparam int SPAN_W  = 32;   // timespan width
	localparam int ACT_W   = 34;   // clamped elapsed time, up to 4x timespan
	localparam int PROD_W  = 57;   // mantissa times elapsed time
	localparam int QUO_W   = 25;   // quotient is below 4x mantissa range
	localparam int EXPO_W  = 9;    // exponent during normalization, up to 256
	localparam int LIMIT_W = 256;
	localparam int CIDX_W  = 3;
	localparam int CDAT_W  = 64;

	// register indexes of the config port
	localparam logic [CIDX_W-1:0] REG_NO_RETARGET     = 3'd0;
	localparam logic [CIDX_W-1:0] REG_TARGET_TIMESPAN = 3'd1;
	localparam logic [CIDX_W-1:0] REG_LIMIT_WORD0     = 3'd2;
	localparam logic [CIDX_W-1:0] REG_LIMIT_WORD1     = 3'd3;
	localparam logic [CIDX_W-1:0] REG_LIMIT_WORD2     = 3'd4;
	localparam logic [CIDX_W-1:0] REG_LIMIT_WORD3     = 3'd5;

	localparam logic [SPAN_W-1:0] SPAN_RESET   = 32'd1209600;
	localparam logic [CDAT_W-1:0] LIMIT_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [CDAT_W-1:0] LIMIT3_RESET = 64'h0000_0000_FFFF_FFFF;

	localparam logic [QUO_W-1:0]  MANT_MAX  = 25'h07F_FFFF;
	localparam logic [QUO_W-1:0]  NORM_MIN  = 25'h000_8000;
	localparam logic [EXPO_W-1:0] EXPO_MIN  = 9'd1;
	localparam logic [EXPO_W-1:0] EXPO_MAX  = 9'd32;
	localparam logic [4:0]        DIV_LAST  = 5'd24;   // 25 quotient bits
	localparam logic [5:0]        NUM_BYTES = 6'd32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_MUL,
		ST_DIV,
		ST_NINIT,
		ST_NORM,
		ST_EXPAND,
		ST_CMP,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic               no_retarget;
		logic [SPAN_W-1:0]  span;
		logic [LIMIT_W-1:0] limit;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic clamp;
		logic mul;
		logic div_step;
		logic norm_init;
		logic norm_step;
		logic expand;
		logic compare;
		logic scan_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic bypass;
		logic norm_done;
		logic over;
		logic scan_done;
	} sts_t;

endpackage

// File: hdl/cdr_cfg.sv
// ----------------------------------------------------------------------------
// cdr_cfg
// configuration registers, written through a plain write port
// ----------------------------------------------------------------------------
module cdr_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [cdr_pkg::CIDX_W-1:0] cfg_index,
	input  logic [cdr_pkg::CDAT_W-1:0] cfg_wdata,
	output cdr_pkg::cfg_t              cfg
);
	import cdr_pkg::*;

	logic                 no_retarget_q;
	logic [SPAN_W-1:0]    span_q;
	logic [LIMIT_W-1:0]   limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_retarget_q <= 1'b0;
			span_q        <= SPAN_RESET;
			limit_q       <= {LIMIT3_RESET, LIMIT_ONES, LIMIT_ONES, LIMIT_ONES};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NO_RETARGET:     no_retarget_q     <= cfg_wdata[0];
				REG_TARGET_TIMESPAN: span_q            <= cfg_wdata[SPAN_W-1:0];
				REG_LIMIT_WORD0:     limit_q[63:0]     <= cfg_wdata;
				REG_LIMIT_WORD1:     limit_q[127:64]   <= cfg_wdata;
				REG_LIMIT_WORD2:     limit_q[191:128]  <= cfg_wdata;
				REG_LIMIT_WORD3:     limit_q[255:192]  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.no_retarget = no_retarget_q;
	assign cfg.span        = span_q;
	assign cfg.limit       = limit_q;

endmodule

// File: hdl/cdr_dp.sv
// ----------------------------------------------------------------------------
// cdr_dp
// datapath: clamp, multiply, serial divide, normalize, expand, compare, limit scan
// ----------------------------------------------------------------------------
module cdr_dp (
	input  logic          clk,
	input  cdr_pkg::cmd_t cmd,
	input  cdr_pkg::cfg_t cfg,
	input  logic [31:0]   old_bits,
	input  logic [31:0]   last_time,
	input  logic [31:0]   first_time,
	output cdr_pkg::sts_t sts,
	output logic [31:0]   new_bits,
	output logic          hit_limit
);
	import cdr_pkg::*;

	logic [31:0]        old_q;
	logic [32:0]        diff_q;
	logic [ACT_W-1:0]   act_q;
	logic [SPAN_W-1:0]  rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic [QUO_W-1:0]   scaled_q;
	logic [EXPO_W-1:0]  expo_q;
	logic [31:0]        nb_q;
	logic [LIMIT_W-1:0] val_q;
	logic [LIMIT_W-1:0] lim_q;
	logic [5:0]         size_q;
	logic               byp_q;
	logic               over_q;

	// clamp of elapsed time
	logic [ACT_W-1:0]   lo;
	logic [ACT_W-1:0]   hi;
	logic [ACT_W-1:0]   diff_mag;
	logic [ACT_W-1:0]   act_d;

	assign lo       = {4'b0000, cfg.span[SPAN_W-1:2]};
	assign hi       = {cfg.span, 2'b00};
	assign diff_mag = {2'b00, diff_q[31:0]};

	always_comb begin
		if (diff_q[32] || (diff_mag < lo)) begin
			act_d = lo;
		end else if (diff_mag > hi) begin
			act_d = hi;
		end else begin
			act_d = diff_mag;
		end
	end

	// product and one restoring divide step
	logic [PROD_W-1:0]  prod;
	logic [SPAN_W:0]    trial;
	logic [SPAN_W:0]    trial_sub;
	logic               trial_ge;

	assign prod      = {{(PROD_W-MANT_W){1'b0}}, old_q[MANT_W-1:0]} *
	                   {{(PROD_W-ACT_W){1'b0}}, act_q};
	assign trial     = {rem_q, quo_q[QUO_W-1]};
	assign trial_ge  = trial >= {1'b0, cfg.span};
	assign trial_sub = trial - {1'b0, cfg.span};

	// normalization in byte steps
	logic norm_big;
	logic norm_small;

	assign norm_big   = scaled_q > MANT_MAX;
	assign norm_small = (scaled_q != '0) && (scaled_q < NORM_MIN) && (expo_q > EXPO_MIN);

	// exponent clamp and expansion to 256 bits
	logic [5:0]          ex;
	logic [MANT_W-1:0]   mant;
	logic [LIMIT_W+23:0] wide;

	always_comb begin
		if ((scaled_q == '0) || (expo_q < EXPO_MIN)) begin
			ex = 6'd1;
		end else if (expo_q > EXPO_MAX) begin
			ex = 6'd32;
		end else begin
			ex = expo_q[5:0];
		end
	end

	assign mant = scaled_q[MANT_W-1:0];
	// mant * 256^(ex-3), with the low bytes dropped when ex is below 3
	assign wide = {{(LIMIT_W+24-MANT_W){1'b0}}, mant} << {ex, 3'b000};

	// compact form of the limit from the scanned register
	logic [23:0] lim_top;
	logic [31:0] lim_compact;

	assign lim_top = lim_q[LIMIT_W-1:LIMIT_W-24];

	always_comb begin
		if (lim_top[23]) begin
			lim_compact = {({2'b00, size_q} + 8'd1), 8'h00, lim_top[23:8]};
		end else begin
			lim_compact = {2'b00, size_q, lim_top};
		end
	end

	assign sts.bypass    = cfg.no_retarget;
	assign sts.norm_done = !norm_big && !norm_small;
	assign sts.over      = val_q > cfg.limit;
	assign sts.scan_done = (lim_q[LIMIT_W-1:LIMIT_W-8] != 8'h00) || (size_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			old_q  <= old_bits;
			diff_q <= {1'b0, last_time} - {1'b0, first_time};
			byp_q  <= cfg.no_retarget;
		end
		if (cmd.clamp) begin
			act_q <= act_d;
		end
		if (cmd.mul) begin
			{rem_q, quo_q} <= prod;
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_sub[SPAN_W-1:0] : trial[SPAN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], trial_ge};
		end
		if (cmd.norm_init) begin
			// zero timespan gives a zero quotient
			scaled_q <= (cfg.span == '0) ? '0 : quo_q;
			expo_q   <= {1'b0, old_q[31:24]};
		end
		if (cmd.norm_step) begin
			if (norm_big) begin
				scaled_q <= {8'h00, scaled_q[QUO_W-1:8]};
				expo_q   <= expo_q + 9'd1;
			end else begin
				scaled_q <= {scaled_q[QUO_W-9:0], 8'h00};
				expo_q   <= expo_q - 9'd1;
			end
		end
		if (cmd.expand) begin
			val_q <= wide[LIMIT_W+23:24];
			nb_q  <= {2'b00, ex, 1'b0, mant};
		end
		if (cmd.compare) begin
			over_q <= sts.over;
			lim_q  <= cfg.limit;
			size_q <= NUM_BYTES;
		end
		if (cmd.scan_step) begin
			lim_q  <= {lim_q[LIMIT_W-9:0], 8'h00};
			size_q <= size_q - 6'd1;
		end
		if (cmd.finish) begin
			if (byp_q) begin
				new_bits  <= old_q;
				hit_limit <= 1'b0;
			end else if (over_q) begin
				new_bits  <= lim_compact;
				hit_limit <= 1'b1;
			end else begin
				new_bits  <= nb_q;
				hit_limit <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/cdr_ctrl.sv
// ----------------------------------------------------------------------------
// cdr_ctrl
// sequencer for one retarget item
// ----------------------------------------------------------------------------
module cdr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cdr_pkg::sts_t sts,
	output cdr_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	import cdr_pkg::*;

	state_t     state_q;
	state_t     state_d;
	logic [4:0] cnt_q;
	logic       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FINISH);
			if (state_q == ST_MUL) begin
				cnt_q <= DIV_LAST;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = sts.bypass ? ST_FINISH : ST_CLAMP;
				end
			end
			ST_CLAMP:  state_d = ST_MUL;
			ST_MUL:    state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_NINIT;
				end
			end
			ST_NINIT:  state_d = ST_NORM;
			ST_NORM: begin
				if (sts.norm_done) begin
					state_d = ST_EXPAND;
				end
			end
			ST_EXPAND: state_d = ST_CMP;
			ST_CMP:    state_d = sts.over ? ST_SCAN : ST_FINISH;
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load      = start;
			ST_CLAMP:  cmd.clamp     = 1'b1;
			ST_MUL:    cmd.mul       = 1'b1;
			ST_DIV:    cmd.div_step  = 1'b1;
			ST_NINIT:  cmd.norm_init = 1'b1;
			ST_NORM:   cmd.norm_step = !sts.norm_done;
			ST_EXPAND: cmd.expand    = 1'b1;
			ST_CMP:    cmd.compare   = 1'b1;
			ST_SCAN:   cmd.scan_step = !sts.scan_done;
			ST_FINISH: cmd.finish    = 1'b1;
			default:   cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// File: hdl/compact_difficulty_retarget_top.sv
// ----------------------------------------------------------------------------
// compact_difficulty_retarget_top
// next compact target word from the previous one and the period's block times
// ----------------------------------------------------------------------------
// usage
//   an item (old_bits, last_time, first_time) is taken at a clock edge with
//   start high and busy low; busy then stays high until the result is made
//   the result (new_bits, hit_limit) is valid for the single cycle in which
//   done is high; the receiver cannot stall, so it must take it then
//   new_bits and hit_limit hold their value until the next result
//   configuration: cfg_we, cfg_index, cfg_wdata, one register per index,
//   written only while busy is low and no result is pending
// latency, start edge to done cycle
//   retarget disabled: 2 cycles
//   normal path: 33 to 35 cycles, set by the 25-step restoring divider
//   (one quotient bit per cycle) plus up to two byte normalization steps
//   limit hit: add 1 to 33 cycles for the byte scan that finds the top
//   nonzero byte of the 256-bit limit
//   a new item may be started in the cycle that done is high
// reset
//   arst_n low returns the sequencer to idle, drops done and loads the
//   register reset values; no clearing pass is needed
// ----------------------------------------------------------------------------
module compact_difficulty_retarget_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// command channel
	input  logic                       start,
	output logic                       busy,
	input  logic [31:0]                old_bits,
	input  logic [31:0]                last_time,
	input  logic [31:0]                first_time,
	// result strobe
	output logic                       done,
	output logic [31:0]                new_bits,
	output logic                       hit_limit,
	// config write port
	input  logic                       cfg_we,
	input  logic [cdr_pkg::CIDX_W-1:0] cfg_index,
	input  logic [cdr_pkg::CDAT_W-1:0] cfg_wdata
);
	import cdr_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// config registers, reset to the default timespan and limit
	cdr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// sequencer: one item at a time, drives datapath commands
	cdr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: clamp, multiply, divide, normalize, expand, compare, scan
	cdr_dp u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.cfg        (cfg),
		.old_bits   (old_bits),
		.last_time  (last_time),
		.first_time (first_time),
		.sts        (sts),
		.new_bits   (new_bits),
		.hit_limit  (hit_limit)
	);

endmodule

// File: hdl/cdr_checker.sv
// ----------------------------------------------------------------------------
// cdr_port_checker
// port level checks of the command and result strobes
// ----------------------------------------------------------------------------
module cdr_port_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// an accepted item keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted item");

	// result strobe is a single cycle pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// the result shows only once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// every item that finishes gives a result
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

endmodule

bind compact_difficulty_retarget_top cdr_port_checker u_cdr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

// File: tb/cdr_checker.sv
// ----------------------------------------------------------------------------
// cdr_checker
// watches the retarget command, result and register ports, predicts each
// result from the items and register writes it sees, and compares in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cdr_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [31:0]                old_bits,
	input  logic [31:0]                last_time,
	input  logic [31:0]                first_time,
	input  logic                       done,
	input  logic [31:0]                new_bits,
	input  logic                       hit_limit,
	input  logic                       cfg_we,
	input  logic [cdr_pkg::CIDX_W-1:0] cfg_index,
	input  logic [cdr_pkg::CDAT_W-1:0] cfg_wdata,
	output int                         fail_count,
	output int                         pending,
	output int                         results_seen,
	output int                         limit_hits
);

	import cdr_pkg::*;

	typedef struct packed {
		logic [31:0] old_bits;
		logic [31:0] new_bits;
		logic        hit_limit;
	} target_word_t;

	logic               no_retarget_m;
	logic [SPAN_W-1:0]  span_m;
	logic [LIMIT_W-1:0] limit_m;
	target_word_t       predicted_targets[$];
	int                 err_n;
	int                 seen_n;
	int                 hits_n;

	// compact form of the 256-bit limit, sign fix-up at every size
	function automatic logic [31:0] compact_of_limit(input logic [LIMIT_W-1:0] lim);
		int          top;
		logic [31:0] size;
		logic [23:0] mant;
		top = -1;
		for (int i = 31; i >= 0; i--)
			if (top < 0 && lim[i*8 +: 8] != 8'd0)
				top = i;
		if (top < 0)
			return 32'd0;
		size = 32'(top + 1);
		if (top >= 2)
			mant = 24'(lim >> (8 * (top - 2)));
		else
			mant = 24'(lim[23:0] << (8 * (2 - top)));
		if (mant[23]) begin
			mant = mant >> 8;
			size = size + 32'd1;
		end
		return (size << 24) | {8'd0, mant};
	endfunction

	function automatic target_word_t retarget_bits(input logic [31:0] prev,
			input logic [31:0] t_last, input logic [31:0] t_first);
		target_word_t       r;
		longint             elapsed;
		longint             lo_bound;
		longint             hi_bound;
		logic [63:0]        scaled;
		int                 expo;
		logic [22:0]        mant;
		logic [LIMIT_W-1:0] wide;
		r.old_bits  = prev;
		r.hit_limit = 1'b0;
		if (no_retarget_m) begin
			r.new_bits = prev;
			return r;
		end
		// signed difference, so a clock running backwards clamps up
		elapsed  = longint'({32'd0, t_last}) - longint'({32'd0, t_first});
		lo_bound = longint'({32'd0, span_m}) / 4;
		hi_bound = longint'({32'd0, span_m}) * 4;
		if (elapsed < lo_bound)
			elapsed = lo_bound;
		if (elapsed > hi_bound)
			elapsed = hi_bound;
		scaled = 64'(prev[22:0]) * 64'(elapsed);
		if (span_m == '0)
			scaled = '0;
		else
			scaled = scaled / 64'(span_m);
		expo = int'(prev[31:24]);
		while (scaled > 64'h7F_FFFF) begin
			scaled = scaled >> 8;
			expo++;
		end
		while (scaled < 64'h8000 && expo > 1) begin
			scaled = scaled << 8;
			expo--;
		end
		if (expo > 32)
			expo = 32;
		if (expo < 1)
			expo = 1;
		mant = scaled[22:0];
		wide = LIMIT_W'(mant);
		if (expo <= 3)
			wide = wide >> (8 * (3 - expo));
		else
			wide = wide << (8 * (expo - 3));
		if (wide > limit_m) begin
			r.new_bits  = compact_of_limit(limit_m);
			r.hit_limit = 1'b1;
		end else
			r.new_bits = {expo[7:0], 1'b0, mant};
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		target_word_t want;
		if (!arst_n) begin
			no_retarget_m <= 1'b0;
			span_m        <= SPAN_RESET;
			limit_m       <= {LIMIT3_RESET, LIMIT_ONES, LIMIT_ONES, LIMIT_ONES};
			predicted_targets.delete();
			err_n = 0;
			seen_n = 0;
			hits_n = 0;
			fail_count   <= 0;
			pending      <= 0;
			results_seen <= 0;
			limit_hits   <= 0;
		end else begin
			// results first: an item taken at this edge cannot finish at it
			if (done) begin
				seen_n++;
				if (predicted_targets.size() == 0) begin
					if (err_n < 10)
						$display("%0t: result %08h/%0b with nothing outstanding",
							$realtime, new_bits, hit_limit);
					err_n++;
				end else begin
					want = predicted_targets.pop_front();
					if (want.hit_limit)
						hits_n++;
					if (new_bits !== want.new_bits || hit_limit !== want.hit_limit) begin
						if (err_n < 10)
							$display("%0t: old_bits %08h: new_bits exp %08h got %08h, hit_limit exp %0b got %0b",
								$realtime, want.old_bits, want.new_bits, new_bits,
								want.hit_limit, hit_limit);
						err_n++;
					end
				end
			end
			if (start && !busy)
				predicted_targets.push_back(retarget_bits(old_bits, last_time, first_time));
			if (cfg_we) begin
				case (cfg_index)
					REG_NO_RETARGET:     no_retarget_m <= cfg_wdata[0];
					REG_TARGET_TIMESPAN: span_m <= cfg_wdata[SPAN_W-1:0];
					REG_LIMIT_WORD0:     limit_m[63:0] <= cfg_wdata;
					REG_LIMIT_WORD1:     limit_m[127:64] <= cfg_wdata;
					REG_LIMIT_WORD2:     limit_m[191:128] <= cfg_wdata;
					REG_LIMIT_WORD3:     limit_m[255:192] <= cfg_wdata;
					default: ;
				endcase
			end
			fail_count   <= err_n;
			pending      <= int'(predicted_targets.size());
			results_seen <= seen_n;
			limit_hits   <= hits_n;
		end
	end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives retarget requests and register settings into the compact difficulty
// retarget block; a checker beside it predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	import cdr_pkg::*;

	localparam int     CYCLE_LIMIT       = 1_000_000;
	localparam int     DRAIN_CYCLES      = 80;     // longest item: divide plus full byte scan
	localparam int     RANDOM_SETTINGS   = 9;
	localparam int     ITEMS_PER_SETTING = 125;
	localparam longint TIME_RANGE        = 64'h1_0000_0000;
	// unmapped register index, writes there must be dropped
	localparam logic [CIDX_W-1:0]  REG_SPARE   = 3'd7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT3_RESET, LIMIT_ONES, LIMIT_ONES, LIMIT_ONES};

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [31:0]         old_bits;
	logic [31:0]         last_time;
	logic [31:0]         first_time;
	logic                done;
	logic [31:0]         new_bits;
	logic                hit_limit;
	logic                cfg_we;
	logic [CIDX_W-1:0]   cfg_index;
	logic [CDAT_W-1:0]   cfg_wdata;

	int                  fail_count;
	int                  pending;
	int                  results_seen;
	int                  limit_hits;

	int                  cycle_count = 0;
	int                  idle_pct;
	int                  items_sent;
	int                  settings_run;
	logic [SPAN_W-1:0]   span_now;   // timespan in force, used to shape elapsed times
	logic                nr_sel;
	logic [SPAN_W-1:0]   span_sel;
	logic [LIMIT_W-1:0]  limit_sel;

	compact_difficulty_retarget_top DUT (.*);

	cdr_checker retarget_chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("no end of run within %0d cycles", CYCLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// one item: random idle gap, then hold start until busy is seen low at an edge
	task automatic push_retarget(input logic [31:0] o, input logic [31:0] l,
			input logic [31:0] f);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		old_bits   <= o;
		last_time  <= l;
		first_time <= f;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	// stop sending and wait until every outstanding result has come back
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
	endtask

	// cfg_we stays high across back-to-back writes, lowered by the caller
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// every register, with junk in the unused upper data bits
	task automatic program_config(input logic nr, input logic [SPAN_W-1:0] span,
			input logic [LIMIT_W-1:0] lim);
		settle();
		write_reg(REG_NO_RETARGET, {32'($urandom), 31'($urandom), nr});
		write_reg(REG_TARGET_TIMESPAN, {32'($urandom), span});
		write_reg(REG_LIMIT_WORD0, lim[63:0]);
		write_reg(REG_LIMIT_WORD1, lim[127:64]);
		write_reg(REG_LIMIT_WORD2, lim[191:128]);
		write_reg(REG_LIMIT_WORD3, lim[255:192]);
		write_reg(REG_SPARE, {32'($urandom), 32'($urandom)});
		cfg_we   <= 1'b0;
		span_now = span;
		settings_run++;
	endtask

	function automatic logic [SPAN_W-1:0] span_shape();
		case ($urandom_range(7))
			0:       return 32'd1;
			1:       return '1;
			2:       return SPAN_RESET;
			3:       return 32'($urandom_range(2, 64));
			4:       return 32'($urandom_range(100, 100_000));
			5:       return 32'($urandom_range(1, 2_000_000));
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic logic [LIMIT_W-1:0] limit_shape();
		logic [LIMIT_W-1:0] v;
		v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(9))
			0, 1:    return LIMIT_RESET;
			2:       return '1;
			3:       return v;
			// random value trimmed to a random byte length
			4, 5, 6: return v & ((LIMIT_W'(1) << (8 * $urandom_range(1, 32))) - 1);
			// shaped like an expanded compact word
			7, 8:    return LIMIT_W'(v[22:0]) << (8 * ($urandom_range(4, 32) - 3));
			default: return '0;
		endcase
	endfunction

	// mostly elapsed times inside the clamp window, some below it, some negative
	task automatic push_random_item();
		logic [7:0]  expo_b;
		logic [22:0] mant_b;
		logic [31:0] t_first;
		logic [31:0] t_last;
		longint      span_l;
		longint      gap;
		longint      room;
		longint      r64;
		int          pick;
		span_l = longint'({32'd0, span_now});
		r64    = longint'({$urandom, $urandom} >> 1);
		expo_b = ($urandom_range(99) < 75) ? 8'($urandom_range(1, 34)) : 8'($urandom);
		if ($urandom_range(3) == 0)
			mant_b = 23'($urandom & ((32'd1 << $urandom_range(0, 23)) - 1));
		else
			mant_b = 23'($urandom);
		pick = $urandom_range(99);
		if (pick < 55)
			gap = span_l / 4 + r64 % (span_l * 4 - span_l / 4 + 1);
		else if (pick < 70)
			gap = span_l + longint'($urandom_range(0, 16)) - 8;
		else if (pick < 80)
			gap = r64 % (span_l / 4 + 1);
		else
			gap = -1 - r64 % TIME_RANGE;
		if (gap > TIME_RANGE - 1)
			gap = TIME_RANGE - 1;
		if (gap < 1 - TIME_RANGE)
			gap = 1 - TIME_RANGE;
		// place the pair so the 32-bit timestamps do not wrap
		room    = TIME_RANGE - ((gap < 0) ? -gap : gap);
		t_first = 32'(((gap < 0) ? -gap : 0) + longint'($urandom) % room);
		t_last  = 32'(longint'(t_first) + gap);
		if (pick >= 95) begin
			t_first = $urandom;
			t_last  = $urandom;
		end
		push_retarget({expo_b, 1'($urandom), mant_b}, t_last, t_first);
	endtask

	initial begin
		arst_n     <= 1'b0;
		start      <= 1'b0;
		old_bits   <= '0;
		last_time  <= '0;
		first_time <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_NO_RETARGET;
		cfg_wdata  <= '0;
		idle_pct     = 26;
		items_sent   = 0;
		settings_run = 1;
		span_now     = SPAN_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items on the reset settings
		push_retarget(32'h1d00_ffff, 32'd1000 + SPAN_RESET, 32'd1000);          // on schedule
		push_retarget(32'h1d00_ffff, '1, '0);                                   // clamp at four times
		push_retarget(32'h1b04_04cb, 32'd5000, 32'd9000);                       // time went backwards
		push_retarget(32'h1b04_04cb, 32'd77, 32'd77);                           // zero elapsed
		push_retarget(32'h1c0f_ffff, 32'd2000 + SPAN_RESET / 4, 32'd2000);      // exactly a quarter
		push_retarget(32'h1c0f_ffff, 32'd2000 + SPAN_RESET * 4, 32'd2000);      // exactly four times
		push_retarget(32'h0000_0000, 32'd10, 32'd5);                            // all-zero word
		push_retarget(32'h2000_0000, 32'd1000 + SPAN_RESET, 32'd1000);          // zero mantissa, ends at exponent 1
		push_retarget(32'h0500_0001, 32'd1000 + SPAN_RESET, 32'd1000);          // tiny mantissa
		push_retarget(32'h0100_3456, 32'd1000 + SPAN_RESET, 32'd1000);          // exponent 1
		push_retarget(32'h0200_8000, 32'd1000 + SPAN_RESET * 2, 32'd1000);      // exponent 2
		push_retarget(32'h0312_3456, 32'd1000 + SPAN_RESET / 2, 32'd1000);      // exponent 3
		push_retarget(32'hff7f_ffff, '1, '0);                                   // exponent clamp, over limit
		push_retarget(32'h1d80_ffff, 32'd1000 + SPAN_RESET, 32'd1000);          // sign bit ignored
		push_retarget('1, '0, '0);

		// retarget disabled: word passes through
		program_config(1'b1, SPAN_RESET, LIMIT_RESET);
		push_retarget('1, '1, '0);
		push_retarget(32'h1d00_ffff, '0, '1);

		// zero timespan: elapsed and quotient both collapse to zero
		program_config(1'b0, '0, LIMIT_RESET);
		push_retarget('1, '1, '0);
		push_retarget(32'h1d00_ffff, 32'd100, 32'd50);

		// zero limit: any nonzero target is over it
		program_config(1'b0, 32'd1, '0);
		push_retarget(32'h1d00_ffff, 32'd5, 32'd4);
		push_retarget(32'h0300_0000, 32'd5, 32'd4);

		// one-byte limit with the top bit set, widest timespan
		program_config(1'b0, '1, LIMIT_W'(32'h80));
		push_retarget(32'h0400_1234, '1, '0);

		// three-byte limit
		program_config(1'b0, 32'd3, LIMIT_W'(32'h12_3456));
		push_retarget(32'h1d00_ffff, 32'd9, 32'd0);

		// limit near the top of the range, compact size grows to 32
		program_config(1'b0, SPAN_RESET, LIMIT_W'(8'h80) << 240);
		push_retarget(32'hff7f_ffff, '1, '0);

		// two-byte limit, small target stays under it
		program_config(1'b0, SPAN_RESET, LIMIT_W'(16'h7f00));
		push_retarget(32'h0400_0001, 32'd1000 + SPAN_RESET, 32'd1000);

		// random part: each setting gets a sender idle rate of 0, 88 or 26 percent
		for (int k = 0; k < RANDOM_SETTINGS; k++) begin
			if (k == 0) begin
				nr_sel    = 1'b0;
				span_sel  = 32'd1;
				limit_sel = LIMIT_RESET;
			end else if (k == 1) begin
				nr_sel    = 1'b0;
				span_sel  = '1;
				limit_sel = '1;
			end else if (k == 2) begin
				nr_sel    = 1'b1;
				span_sel  = span_shape();
				limit_sel = limit_shape();
			end else begin
				nr_sel    = ($urandom_range(7) == 0);
				span_sel  = span_shape();
				limit_sel = limit_shape();
			end
			program_config(nr_sel, span_sel, limit_sel);
			idle_pct = (k % 3 == 0) ? 0 : (k % 3 == 1) ? 88 : 26;
			repeat (ITEMS_PER_SETTING) begin
				// now and then let the block run completely dry
				if ($urandom_range(63) == 0)
					settle();
				push_random_item();
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items over %0d register settings, %0d results checked, %0d clamped to the limit",
			items_sent, settings_run, results_seen, limit_hits);
		$display("timespans 0 to 2^32-1, elapsed times below, inside and above the clamp, bypass on and off");
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hdl/cdr_pkg.sv
hdl/cdr_cfg.sv
hdl/cdr_dp.sv
hdl/cdr_ctrl.sv
hdl/compact_difficulty_retarget_top.sv
hdl/cdr_checker.sv
tb/cdr_checker.sv
tb/tb_top.sv
